// ----- hdl/reec_pkg.sv -----
// Shared constants, types and the Phred probability table builder.
package reec_pkg;

  localparam int BASE_W = 8;
  localparam int QUAL_W = 8;
  localparam int OUT_W  = 13;

  localparam int DEF_MAX_READ_LEN  = 4096;
  localparam int DEF_FRACTION_BITS = 24;

  localparam int QUAL_OFFSET   = 33;  // ASCII offset of Phred characters
  localparam int DEFAULT_PHRED = 20;  // 0.01, used for characters below the offset

  localparam int PROB_TBL_DEPTH = 2 ** QUAL_W;

  // 10^(-b/10) scaled by 10^16, b = 0..9
  localparam logic [63:0] DEC_SCALE = 64'd10000000000000000;
  localparam logic [63:0] TENTH_ROOT_POW [10] = '{
    64'd10000000000000000, 64'd7943282347242815, 64'd6309573444801932,
    64'd5011872336272722,  64'd3981071705534973, 64'd3162277660168379,
    64'd2511886431509580,  64'd1995262314968880, 64'd1584893192461113,
    64'd1258925411794167
  };

  typedef logic [63:0] prob_tbl_t [PROB_TBL_DEPTH];

  // Error probability of Phred score n, unsigned Q1.fb. Elaboration only.
  function automatic logic [63:0] phred_prob(input int unsigned n, input int unsigned fb);
    logic [63:0] d;
    logic [63:0] w;
    logic [63:0] rem;
    int unsigned a;
    int unsigned b;
    a   = n / 10;
    b   = n % 10;
    d   = TENTH_ROOT_POW[b[3:0]];
    w   = d / DEC_SCALE;
    rem = d % DEC_SCALE;
    // 56 fraction bits by long division
    for (int i = 0; i < 56; i++) begin
      w   = w << 1;
      rem = rem << 1;
      if (rem >= DEC_SCALE) begin
        rem  = rem - DEC_SCALE;
        w[0] = 1'b1;
      end
    end
    if ((rem << 1) >= DEC_SCALE) begin
      w = w + 64'd1;
    end
    for (int unsigned i = 0; i < a; i++) begin
      w = w / 64'd10;
    end
    return (w + (64'd1 << (55 - fb))) >> (56 - fb);
  endfunction

  // Probability for every quality character, indexed by the raw byte.
  function automatic prob_tbl_t build_prob_table(input int unsigned fb);
    prob_tbl_t t;
    for (int q = 0; q < PROB_TBL_DEPTH; q++) begin
      if (q >= QUAL_OFFSET) begin
        t[q] = phred_prob(q - QUAL_OFFSET, fb);
      end else begin
        t[q] = phred_prob(DEFAULT_PHRED, fb);
      end
    end
    return t;
  endfunction

endpackage

// ----- hdl/reec_in_if.sv -----
// Input channel: one base with its quality character per transfer.
interface reec_in_if;
  logic                       valid;
  logic                       ready;
  logic [reec_pkg::BASE_W-1:0] base;
  logic [reec_pkg::QUAL_W-1:0] quality;
  logic                       last_in_read;

  modport source (output valid, output base, output quality, output last_in_read,
                  input ready);
  modport sink   (input valid, input base, input quality, input last_in_read,
                  output ready);
endinterface

// ----- hdl/reec_out_if.sv -----
// Result channel: expected error count of one read per transfer.
interface reec_out_if;
  logic                       valid;
  logic                       ready;
  logic [reec_pkg::OUT_W-1:0] expected_errors;

  modport source (output valid, output expected_errors, input ready);
  modport sink   (input valid, input expected_errors, output ready);
endinterface

// ----- hdl/reec_prob_rom.sv -----
// Quality character to error probability lookup (constant table).
module reec_prob_rom #(
  parameter int FRACTION_BITS = reec_pkg::DEF_FRACTION_BITS
) (
  input  logic [reec_pkg::QUAL_W-1:0] quality,
  output logic [FRACTION_BITS:0]      prob
);
  import reec_pkg::*;

  localparam prob_tbl_t PROB_TBL = build_prob_table(FRACTION_BITS);

  assign prob = PROB_TBL[quality][FRACTION_BITS:0];

endmodule

// ----- hdl/read_expected_error_count.sv -----
// Top level: expected sequencing-error count of a read from Phred qualities.
//
// in_ch  : one base, its ASCII quality character and a last-of-read mark per
//          transfer. Characters below '!' count as quality 20 (p = 0.01).
// out_ch : one transfer per read, on its last base: ceil(sum of error
//          probabilities), 13 bits, saturating at MAX_READ_LEN.
// cfg    : cfg_wr_en / cfg_wr_data write compress_runs (reset 1). With it set,
//          each run of equal bases counts once with its smallest probability.
//          Write only while the block is idle.
// Path:    out_ch.valid rises once the last base has passed the lookup register
//          and been written into the output queue; a full queue holds that base
//          in the lookup register until a slot frees.
// Throughput: one base per cycle unless a last base waits on a full queue;
//          bounded by the single saturating add in the accumulator stage.
// Stalls: results sit in a two-entry output queue. in_ch keeps taking bases
//          while the queue holds a result; only a last base waits when the
//          queue is full. in_ch.ready depends on registers only.
// Reset (rst_n low, synchronous): pipeline and queue empty, accumulator
//          cleared, compress_runs = 1.
module read_expected_error_count #(
  parameter int MAX_READ_LEN  = reec_pkg::DEF_MAX_READ_LEN,
  parameter int FRACTION_BITS = reec_pkg::DEF_FRACTION_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  reec_in_if.sink       in_ch,
  reec_out_if.source    out_ch,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data
);
  import reec_pkg::*;

  localparam int PW    = FRACTION_BITS + 1;                      // probability width
  localparam int SUM_W = $clog2(MAX_READ_LEN + 1) + FRACTION_BITS;
  localparam int CW    = SUM_W - FRACTION_BITS + 1;              // ceiling width
  localparam logic [SUM_W-1:0] SUM_CAP = SUM_W'(MAX_READ_LEN) << FRACTION_BITS;
  localparam int Q_DEPTH = 2;
  localparam logic [1:0] Q_FULL = 2'(Q_DEPTH);

  // lookup stage
  logic              s1_valid_r, s1_valid_nxt;
  logic [BASE_W-1:0] s1_base_r;
  logic [PW-1:0]     s1_prob_r;
  logic              s1_last_r;
  logic [PW-1:0]     lut_prob;
  logic              in_fire, s1_move;

  // accumulator state
  logic              compress_r;
  logic [BASE_W-1:0] prev_base_r, prev_base_nxt;
  logic [PW-1:0]     run_min_r, run_min_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              in_read_r, in_read_nxt;

  // result queue
  logic [OUT_W-1:0]  q_data_r [Q_DEPTH];
  logic              q_wr_ptr_r, q_rd_ptr_r;
  logic [1:0]        q_cnt_r, q_cnt_nxt;
  logic              q_push, q_pop;

  // update datapath
  logic              same_run;
  logic [PW-1:0]     prob_min;
  logic [PW-1:0]     add_a, add_b;
  logic [PW:0]       addend;
  logic [SUM_W:0]    sum_raw;
  logic [SUM_W-1:0]  sum_new;
  logic [CW-1:0]     ceil_full;
  logic [OUT_W-1:0]  result;

  reec_prob_rom #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_prob_rom (
    .quality (in_ch.quality),
    .prob    (lut_prob)
  );

  // A last base needs a free queue slot; the count is taken as registered.
  assign s1_move     = s1_valid_r && (!s1_last_r || (q_cnt_r != Q_FULL));
  assign in_ch.ready = !s1_valid_r || s1_move;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_move);

  // Both pending terms are merged into one addend, so one saturating add
  // covers what would otherwise be two back-to-back saturating adds.
  always_comb begin
    same_run = in_read_r && (s1_base_r == prev_base_r);
    prob_min = (s1_prob_r < run_min_r) ? s1_prob_r : run_min_r;
    add_a    = '0;
    add_b    = '0;
    if (compress_r) begin
      if (same_run) begin
        add_a       = s1_last_r ? prob_min : '0;
        run_min_nxt = s1_last_r ? '0 : prob_min;
      end else begin
        add_a       = run_min_r;
        add_b       = s1_last_r ? s1_prob_r : '0;
        run_min_nxt = s1_last_r ? '0 : s1_prob_r;
      end
    end else begin
      add_a       = run_min_r;
      add_b       = s1_prob_r;
      run_min_nxt = '0;
    end
    addend  = {1'b0, add_a} + {1'b0, add_b};
    sum_raw = {1'b0, sum_r} + (SUM_W + 1)'(addend);
    sum_new = (sum_raw >= {1'b0, SUM_CAP}) ? SUM_CAP : sum_raw[SUM_W-1:0];

    ceil_full = CW'(sum_new >> FRACTION_BITS) + CW'(|sum_new[FRACTION_BITS-1:0]);
    result    = OUT_W'(ceil_full);

    if (s1_last_r) begin
      sum_nxt       = '0;
      prev_base_nxt = '0;
      in_read_nxt   = 1'b0;
    end else begin
      sum_nxt       = sum_new;
      prev_base_nxt = s1_base_r;
      in_read_nxt   = 1'b1;
    end
  end

  assign q_push    = s1_move && s1_last_r;
  assign q_pop     = out_ch.valid && out_ch.ready;
  assign q_cnt_nxt = q_cnt_r + 2'(q_push) - 2'(q_pop);

  assign out_ch.valid           = (q_cnt_r != 2'd0);
  assign out_ch.expected_errors = q_data_r[q_rd_ptr_r];

  // control and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      compress_r  <= 1'b1;
      prev_base_r <= '0;
      run_min_r   <= '0;
      sum_r       <= '0;
      in_read_r   <= 1'b0;
      q_wr_ptr_r  <= 1'b0;
      q_rd_ptr_r  <= 1'b0;
      q_cnt_r     <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_wr_en) begin
        compress_r <= cfg_wr_data;
      end
      if (s1_move) begin
        prev_base_r <= prev_base_nxt;
        run_min_r   <= run_min_nxt;
        sum_r       <= sum_nxt;
        in_read_r   <= in_read_nxt;
      end
      if (q_push) begin
        q_wr_ptr_r <= !q_wr_ptr_r;
      end
      if (q_pop) begin
        q_rd_ptr_r <= !q_rd_ptr_r;
      end
      q_cnt_r <= q_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_base_r <= in_ch.base;
      s1_prob_r <= lut_prob;
      s1_last_r <= in_ch.last_in_read;
    end
    if (q_push) begin
      q_data_r[q_wr_ptr_r] <= result;
    end
  end

endmodule

// ----- tb/sv/expected_error_checker.sv -----
`timescale 1ns / 1ps
// Checker for read_expected_error_count: predicts each read's error count and compares it.
module expected_error_checker (
  input  logic clk,
  input  logic rst_n,
  reec_in_if   in_mon,
  reec_out_if  out_mon,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  output int   mismatches,
  output int   outstanding
);
  import reec_pkg::*;

  localparam int FRAC = DEF_FRACTION_BITS;
  localparam logic [36:0] SUM_CAP = 37'(DEF_MAX_READ_LEN) << FRAC;
  localparam logic [37:0] ONE     = 38'd1 << FRAC;

  // predictor state
  logic        runs_mode;
  logic [7:0]  last_base;
  logic [24:0] run_min;
  logic [36:0] err_sum;
  logic        read_open;

  logic [OUT_W-1:0] read_counts[$];
  int fail_tally = 0;
  int open_count = 0;

  assign mismatches  = fail_tally;
  assign outstanding = open_count;

  // 10^(-score/10) in Q1.FRAC: round the digit table to 56 bits, scale down by tens.
  function automatic logic [24:0] phred_error_prob(input int unsigned score);
    logic [127:0] scaled;
    logic [63:0]  w;
    scaled = (128'(TENTH_ROOT_POW[score % 10]) << 57) + 128'(DEC_SCALE);
    scaled = scaled / (128'(DEC_SCALE) << 1);
    w = scaled[63:0];
    repeat (score / 10) w = w / 64'd10;
    return 25'((w + (64'd1 << (55 - FRAC))) >> (56 - FRAC));
  endfunction

  task automatic add_capped(input logic [24:0] v);
    if (37'(v) >= SUM_CAP || err_sum >= SUM_CAP - 37'(v)) err_sum = SUM_CAP;
    else err_sum = err_sum + 37'(v);
  endtask

  task automatic accumulate_base(input logic [7:0] b, input logic [7:0] q, input logic fin);
    logic [24:0] p;
    logic [37:0] rounded;
    p = (q >= QUAL_OFFSET) ? phred_error_prob(q - QUAL_OFFSET)
                           : phred_error_prob(DEFAULT_PHRED);
    if (runs_mode) begin
      if (read_open && b == last_base) begin
        if (p < run_min) run_min = p;
      end else begin
        add_capped(run_min);
        run_min = p;
      end
    end else begin
      add_capped(run_min);
      add_capped(p);
      run_min = '0;
    end
    last_base = b;
    read_open = 1'b1;
    if (fin) begin
      add_capped(run_min);
      rounded = (38'(err_sum) + ONE - 38'd1) >> FRAC;
      read_counts.insert(read_counts.size(), rounded[OUT_W-1:0]);
      last_base = '0;
      run_min   = '0;
      err_sum   = '0;
      read_open = 1'b0;
    end
  endtask

  task automatic report(input string what, input logic [OUT_W-1:0] got,
                        input logic [OUT_W-1:0] want);
    $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_tally++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      runs_mode = 1'b1;
      last_base = '0;
      run_min   = '0;
      err_sum   = '0;
      read_open = 1'b0;
      read_counts.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (read_counts.size() == 0) report("result with none pending", out_mon.expected_errors, '0);
        else begin
          if (out_mon.expected_errors !== read_counts[0])
            report("expected_errors mismatch", out_mon.expected_errors, read_counts[0]);
          void'(read_counts.pop_front());
        end
      end
      if (in_mon.valid && in_mon.ready)
        accumulate_base(in_mon.base, in_mon.quality, in_mon.last_in_read);
      if (cfg_wr_en) runs_mode = cfg_wr_data;
    end
    open_count <= read_counts.size();
  end

endmodule

// ----- tb/sv/read_expected_error_count_tb.sv -----
`timescale 1ns / 1ps
// Top of the read_expected_error_count testbench: clock, reset, stimulus and verdict.
module read_expected_error_count_tb;
  import reec_pkg::*;

  // compress_runs settings
  localparam logic RUNS_OFF = 1'b0;
  localparam logic RUNS_ON  = 1'b1;

  localparam int RANDOM_ITEMS = 1330;
  localparam int DRAIN_CYCLES = 4;     // two-stage pipeline plus margin

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  int  mismatches;
  int  outstanding;
  int  items_sent = 0;
  int  ready_hold = 0;
  bit  burst = 1'b0;   // sender runs with no gaps while set

  reec_in_if  in_ch();
  reec_out_if out_ch();

  read_expected_error_count dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  expected_error_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly real nucleotide letters; the odd arbitrary byte keeps every base bit moving.
  function automatic logic [7:0] pick_base();
    string letters;
    letters = "ACGTN";
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return letters[$urandom_range(0, 4)];
  endfunction

  // Qualities: the usual '!'..'J' band, below-offset characters, and very high ones.
  function automatic logic [7:0] pick_quality();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(QUAL_OFFSET, QUAL_OFFSET + 41));
    if (r < 85) return 8'($urandom_range(0, QUAL_OFFSET - 1));
    return 8'($urandom_range(QUAL_OFFSET + 42, 255));
  endfunction

  function automatic int pick_run();
    if ($urandom_range(0, 3) == 0) return $urandom_range(2, 8);
    return $urandom_range(1, 2);
  endfunction

  // Result-side backpressure: ready is held for a random stretch, then redrawn.
  // Ready-high stretches can be long, so some reads drain with no stall at all.
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 2) != 0);
      ready_hold   <= pick_gap();
    end
  end

  // One base transfer. valid stays high between back-to-back bases; it drops only
  // for a gap, so it never gets two assignments in one step.
  task automatic send_base(input logic [7:0] b, input logic [7:0] q, input logic fin);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.base         <= b;
    in_ch.quality      <= q;
    in_ch.last_in_read <= fin;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Stop sending and wait for every pending count to come back, then let the
  // pipeline empty out (bases that end no read still pass through it).
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // compress_runs is only written with the block idle.
  task automatic write_mode(input logic v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // A well-formed read: runs of equal bases, last flag on the final one.
  // With split set, the mode is rewritten at a random point inside the read.
  task automatic send_read(input int len, input bit split);
    int cut;
    int run_left;
    logic [7:0] b;
    cut = split ? $urandom_range(1, len - 1) : -1;
    run_left = 0;
    b = '0;
    for (int i = 0; i < len; i++) begin
      if (i == cut) write_mode(1'($urandom_range(0, 1)));
      if (run_left == 0) begin
        b = pick_base();
        run_left = pick_run();
      end
      run_left--;
      send_base(b, pick_quality(), i == len - 1);
    end
  endtask

  // Timeout guard, well beyond the slowest legal run.
  initial begin
    #4ms;
    $display("read_expected_error_count_tb NOT OK");
    $finish;
  end

  initial begin
    int start;
    int len;
    int r;
    in_ch.valid        <= 1'b0;
    in_ch.base         <= '0;
    in_ch.quality      <= '0;
    in_ch.last_in_read <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= 1'b0;
    rst_n              <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, runs compressed (reset value) ---
    // single-base reads: quality at the offset (p = 1.0), all-zero bytes
    // (below offset, default 0.01), all-ones bytes (probability rounds to 0)
    send_base("A", 8'(QUAL_OFFSET), 1'b1);
    send_base(8'h00, 8'h00, 1'b1);
    send_base(8'hFF, 8'hFF, 1'b1);
    // runs with quality that rises and falls; below-offset and high chars
    send_base(8'h00, 8'(QUAL_OFFSET + 10), 1'b0);  // base 0 still opens a run
    send_base("A", 8'(QUAL_OFFSET + 10), 1'b0);
    send_base("A", 8'(QUAL_OFFSET + 20), 1'b0);
    send_base("A", 8'(QUAL_OFFSET + 3), 1'b0);
    send_base("C", 8'(QUAL_OFFSET), 1'b0);
    send_base("C", 8'(QUAL_OFFSET - 1), 1'b0);
    send_base("G", 8'd126, 1'b1);

    // --- same pattern, each base counted ---
    write_mode(RUNS_OFF);
    send_base("A", 8'(QUAL_OFFSET + 10), 1'b0);
    send_base("A", 8'(QUAL_OFFSET + 20), 1'b0);
    send_base("A", 8'(QUAL_OFFSET + 3), 1'b0);
    send_base("C", 8'(QUAL_OFFSET - 1), 1'b0);
    send_base(8'hFF, 8'(QUAL_OFFSET + 40), 1'b1);

    // mode switched mid-read: the open run then has minimum 0, so the
    // following equal bases add nothing
    send_base("T", 8'(QUAL_OFFSET + 10), 1'b0);
    write_mode(RUNS_ON);
    send_base("T", 8'(QUAL_OFFSET + 20), 1'b0);
    send_base("T", 8'(QUAL_OFFSET), 1'b0);
    send_base("G", 8'(QUAL_OFFSET + 30), 1'b1);

    // --- random reads ---
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // pause until everything is back, then pick a mode
        write_mode(1'($urandom_range(0, 1)));
      end else if (r < 20) begin
        // noise: arbitrary bytes, last flag at random
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
          send_base(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 4) == 0));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 85) len = $urandom_range(1, 24);
        else if (r < 98) len = $urandom_range(25, 120);
        else len = $urandom_range(121, 400);
        burst = ($urandom_range(0, 4) == 0);
        send_read(len, (len >= 2) && ($urandom_range(0, 9) == 0));
        burst = 1'b0;
      end
    end

    // drain and verdict
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("read_expected_error_count_tb OK");
    end else begin
      $display("read_expected_error_count_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/reec_pkg.sv
hdl/reec_in_if.sv
hdl/reec_out_if.sv
hdl/reec_prob_rom.sv
hdl/read_expected_error_count.sv
tb/sv/expected_error_checker.sv
tb/sv/read_expected_error_count_tb.sv
